### rtl/sha1md_pkg.sv
// Shared types, constants and command/status structs for the SHA-1 digest unit.
package sha1md_pkg;

	localparam int unsigned BLOCK_BYTES  = 64;
	localparam int unsigned FILL_W       = $clog2(BLOCK_BYTES);
	localparam int unsigned COUNT_W      = 61;
	localparam int unsigned LEN_W        = 64;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned WIN_WORDS    = 16;
	localparam int unsigned WIN_W        = WIN_WORDS * WORD_W;
	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned IDX_W        = 3;
	localparam int unsigned ROUND_W      = 7;

	localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(79);
	localparam logic [ROUND_W-1:0] GRP1_START  = ROUND_W'(20);
	localparam logic [ROUND_W-1:0] GRP2_START  = ROUND_W'(40);
	localparam logic [ROUND_W-1:0] GRP3_START  = ROUND_W'(60);
	localparam logic [FILL_W-1:0]  LAST_FILL   = FILL_W'(63);
	localparam logic [FILL_W-1:0]  LEN_FILL    = FILL_W'(56);
	localparam logic [IDX_W-1:0]   LAST_WORD   = IDX_W'(DIGEST_WORDS - 1);
	localparam logic [7:0]         PAD_MARK    = 8'h80;

	localparam logic [WORD_W-1:0] K_GRP0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_GRP1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_GRP2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_GRP3 = 32'hCA62C1D6;

	localparam logic [DIGEST_WORDS-1:0][WORD_W-1:0] INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_FINISH = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		BYTE_DATA,
		BYTE_MARK,
		BYTE_ZERO,
		BYTE_LEN
	} byte_sel_t;

	typedef enum logic [1:0] {
		GRP_CH,
		GRP_PAR1,
		GRP_MAJ,
		GRP_PAR2
	} round_grp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             shift_en;
		byte_sel_t        byte_sel;
		logic             count_inc;
		logic             count_clr;
		logic             work_load;
		logic             round_en;
		round_grp_t       round_grp;
		logic             chain_add;
		logic             chain_init;
		logic [IDX_W-1:0] out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
	} dp_status_t;

endpackage

### rtl/sha1md_dp.sv
// Datapath: block window, message schedule, round logic, chaining values, byte count.
module sha1md_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sha1md_pkg::dp_cmd_t          cmd,
	input  logic [7:0]                   data_byte,
	output sha1md_pkg::dp_status_t       status,
	output logic [sha1md_pkg::WORD_W-1:0] digest_word
);
	import sha1md_pkg::*;

	logic [WIN_W-1:0]                     win_q;
	logic [FILL_W-1:0]                    fill_q;
	logic [COUNT_W-1:0]                   count_q;
	logic [DIGEST_WORDS-1:0][WORD_W-1:0]  chain_q;
	logic [WORD_W-1:0]                    a_q, b_q, c_q, d_q, e_q;

	logic [LEN_W-1:0]  len_bits;
	logic [LEN_W-1:0]  len_shift;
	logic [7:0]        byte_in;
	logic [WORD_W-1:0] w0, w2, w8, w13, w_mix, w_new;
	logic [WORD_W-1:0] f_val, k_val, t_val;

	assign status.fill = fill_q;
	assign digest_word = chain_q[cmd.out_sel];

	// length bytes go out most significant first at fill 56..63
	assign len_bits  = {count_q, 3'b000};
	assign len_shift = len_bits >> {~fill_q[2:0], 3'b000};

	always_comb begin
		unique case (cmd.byte_sel)
			BYTE_DATA: byte_in = data_byte;
			BYTE_MARK: byte_in = PAD_MARK;
			BYTE_ZERO: byte_in = 8'h00;
			BYTE_LEN:  byte_in = len_shift[7:0];
			default:   byte_in = 8'h00;
		endcase
	end

	// window word j holds W[t+j]; word 0 sits in the top bits
	assign w0  = win_q[WIN_W-1 -: WORD_W];
	assign w2  = win_q[WIN_W-1-2*WORD_W -: WORD_W];
	assign w8  = win_q[WIN_W-1-8*WORD_W -: WORD_W];
	assign w13 = win_q[WIN_W-1-13*WORD_W -: WORD_W];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

	always_comb begin
		unique case (cmd.round_grp)
			GRP_CH: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = K_GRP0;
			end
			GRP_PAR1: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_GRP1;
			end
			GRP_MAJ: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = K_GRP2;
			end
			GRP_PAR2: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_GRP3;
			end
			default: begin
				f_val = '0;
				k_val = '0;
			end
		endcase
	end

	assign t_val = {a_q[WORD_W-6:0], a_q[WORD_W-1:WORD_W-5]} + f_val + e_q + k_val + w0;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			win_q <= {win_q[WIN_W-9:0], byte_in};
		end else if (cmd.round_en) begin
			win_q <= {win_q[WIN_W-WORD_W-1:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.work_load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[WORD_W-1:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			chain_q <= INIT_CHAIN;
		end else begin
			if (cmd.shift_en) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.count_clr) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (cmd.chain_init) begin
				chain_q <= INIT_CHAIN;
			end else if (cmd.chain_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
		end
	end

endmodule

### rtl/sha1md_ctrl.sv
// Controller: request handshakes, padding sequence, round counter, digest output.
module sha1md_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_kind,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sha1md_pkg::IDX_W-1:0]      out_index,
	output logic                              out_last,
	input  sha1md_pkg::dp_status_t            status,
	output sha1md_pkg::dp_cmd_t               cmd
);
	import sha1md_pkg::*;

	state_t             state_q, state_d;
	logic [ROUND_W-1:0] round_q;
	logic [IDX_W-1:0]   word_q;
	logic               finish_q;
	logic               len_ok_q;
	logic               mark_q;
	logic               in_fire, out_fire, block_full;

	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid && out_ready;
	assign block_full = (status.fill == LAST_FILL);
	assign out_index  = word_q;
	assign out_last   = (word_q == LAST_WORD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_kind == KIND_FINISH) begin
						state_d = ST_PAD;
					end else if (block_full) begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				if (block_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (!finish_q) begin
					state_d = ST_IDLE;
				end else if (len_ok_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_fire && out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ready and valid are constant within a state, so the request checks use the peer side only
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd           = '0;
		cmd.byte_sel  = BYTE_DATA;
		cmd.round_grp = GRP_CH;
		cmd.out_sel   = word_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_kind == KIND_APPEND) begin
					cmd.shift_en  = 1'b1;
					cmd.count_inc = 1'b1;
					cmd.work_load = block_full;
				end
			end
			ST_PAD: begin
				cmd.shift_en  = 1'b1;
				cmd.work_load = block_full;
				if (mark_q) begin
					cmd.byte_sel = BYTE_MARK;
				end else if (len_ok_q && status.fill >= LEN_FILL) begin
					cmd.byte_sel = BYTE_LEN;
				end else begin
					cmd.byte_sel = BYTE_ZERO;
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				priority if (round_q < GRP1_START) begin
					cmd.round_grp = GRP_CH;
				end else if (round_q < GRP2_START) begin
					cmd.round_grp = GRP_PAR1;
				end else if (round_q < GRP3_START) begin
					cmd.round_grp = GRP_MAJ;
				end else begin
					cmd.round_grp = GRP_PAR2;
				end
			end
			ST_ADD: begin
				cmd.chain_add = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready && out_last) begin
					cmd.chain_init = 1'b1;
					cmd.count_clr  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			round_q  <= '0;
			word_q   <= '0;
			finish_q <= 1'b0;
			len_ok_q <= 1'b0;
			mark_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) begin
				round_q <= (round_q == LAST_ROUND) ? '0 : round_q + ROUND_W'(1);
			end
			if (in_fire && in_kind == KIND_FINISH) begin
				finish_q <= 1'b1;
				mark_q   <= 1'b1;
			end
			// length fits in this block only if the marker lands before byte 56
			if (state_q == ST_PAD && mark_q) begin
				mark_q   <= 1'b0;
				len_ok_q <= (status.fill < LEN_FILL);
			end
			if (state_q == ST_ADD && finish_q && !len_ok_q) begin
				len_ok_q <= 1'b1;
			end
			if (out_fire) begin
				if (out_last) begin
					word_q   <= '0;
					finish_q <= 1'b0;
				end else begin
					word_q <= word_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

### rtl/sha1_message_digest_unit.sv
// SHA-1 digest unit: append bytes, on finish pad and emit five digest words.
// Append: one byte per cycle while idle; a block's 64th byte starts the rounds and chain add.
// Finish: pad bytes fill the rest of the block, which is then compressed; a marker at fill 56
// or above adds a length block; then five words, one per m_tready cycle.
// One request in flight at a time: s_tready is high only while idle.
// Reset (arst_n low) loads the initial chaining values and clears the byte count.
module sha1_message_digest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);
	import sha1md_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	sha1md_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (m_tuser),
		.out_last  (m_tlast),
		.status    (status),
		.cmd       (cmd)
	);

	sha1md_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (s_tdata),
		.status      (status),
		.digest_word (m_tdata)
	);

endmodule
